// ----- src/slsb_pkg.sv -----
// shared types and constants for the joint slew limiter
package slsb_pkg;

    localparam int NUM_JOINTS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;
    localparam int POS_W          = 32;
    localparam int STEP_W         = 31;
    localparam int CNT_W          = 16;
    localparam int IN_DATA_W      = 136;
    localparam int OUT_DATA_W     = 72;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_STAGE   = 2'd1,
        ACT_PUBLISH = 2'd2,
        ACT_LOAD    = 2'd3
    } action_t;

    localparam logic CFG_STALE_LIMIT = 1'b0;
    localparam logic CFG_DECEL_TICKS = 1'b1;

    typedef struct packed {
        action_t                   kind;
        logic [3:0]                joint;
        logic signed [POS_W-1:0]   position;
        logic                      not_finite;
        logic signed [POS_W-1:0]   low_limit;
        logic signed [POS_W-1:0]   high_limit;
        logic [STEP_W-1:0]         step_limit;
    } item_t;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [POS_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

endpackage

// ----- src/slsb_front.sv -----
// input stage: accepts words, drops out-of-range joints, queues items
module slsb_front #(
    parameter int NUM_JOINTS = slsb_pkg::NUM_JOINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // joint, position, not_finite, low_limit, high_limit, step_limit, zero pad
    input  logic [slsb_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [1:0]                      s_tuser,
    output logic                            q_valid,
    input  logic                            q_ready,
    output slsb_pkg::item_t                 q_item
);

    slsb_pkg::item_t                      in_item;
    slsb_pkg::item_t                      queue_mem [slsb_pkg::QUEUE_DEPTH];
    logic [slsb_pkg::QUEUE_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [slsb_pkg::QUEUE_AW:0]          count_reg, count_next;
    logic                                 drop, push, pop;
    logic [6:0]                           joint_ext;

    always_comb begin
        in_item.kind       = slsb_pkg::action_t'(s_tuser);
        in_item.joint      = s_tdata[3:0];
        in_item.position   = s_tdata[35:4];
        in_item.not_finite = s_tdata[36];
        in_item.low_limit  = s_tdata[68:37];
        in_item.high_limit = s_tdata[100:69];
        in_item.step_limit = s_tdata[131:101];
    end

    assign joint_ext = {3'b000, in_item.joint};
    assign drop = (in_item.kind == slsb_pkg::ACT_STAGE || in_item.kind == slsb_pkg::ACT_LOAD)
                  && (joint_ext >= 7'(NUM_JOINTS));
    assign s_tready = (count_reg < (slsb_pkg::QUEUE_AW+1)'(slsb_pkg::QUEUE_DEPTH));
    assign push = s_tvalid && s_tready && !drop;
    assign q_valid = (count_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_item = queue_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- src/slsb_div.sv -----
// radix-2 restoring divider for the decel step, one quotient bit a cycle
module slsb_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  slsb_pkg::div_req_t              req,
    output logic                            done,
    output logic [slsb_pkg::POS_W-1:0]      quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [4:0]                       cnt_reg;
    logic [slsb_pkg::POS_W-1:0]       quo_reg;
    logic [slsb_pkg::CNT_W-1:0]       rem_reg;
    logic [slsb_pkg::CNT_W-1:0]       dsr_reg;
    logic                             neg_reg;
    logic [slsb_pkg::CNT_W:0]         trial;
    logic [slsb_pkg::CNT_W:0]         diff;
    logic                             fits;

    assign trial = {rem_reg, quo_reg[slsb_pkg::POS_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= (req.divisor == '0) ? slsb_pkg::CNT_W'(1) : req.divisor;
            neg_reg <= req.neg;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[slsb_pkg::POS_W-2:0], fits};
            rem_reg <= fits ? diff[slsb_pkg::CNT_W-1:0] : trial[slsb_pkg::CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ----- src/slsb_back.sv -----
// execution stage: joint state, watchdog, per-joint command update and result register
module slsb_back #(
    parameter int NUM_JOINTS = slsb_pkg::NUM_JOINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  slsb_pkg::item_t                  q_item,
    input  logic [slsb_pkg::CNT_W-1:0]       stale_limit,
    input  logic [slsb_pkg::CNT_W-1:0]       decel_ticks,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [slsb_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_VEL, ST_DIV, ST_CMD} state_t;

    state_t state_reg;

    logic signed [31:0] cmd_mem  [NUM_JOINTS];
    logic signed [31:0] tgt_mem  [NUM_JOINTS];
    logic signed [31:0] prev_mem [NUM_JOINTS];
    logic signed [31:0] dec_mem  [NUM_JOINTS];
    logic signed [31:0] lo_mem   [NUM_JOINTS];
    logic signed [31:0] hi_mem   [NUM_JOINTS];
    logic [30:0]        step_mem [NUM_JOINTS];
    logic signed [31:0] stg_mem  [NUM_JOINTS];
    logic [NUM_JOINTS-1:0] stg_bad_reg;
    logic [NUM_JOINTS-1:0] dec_vld_reg;

    logic        snap_pend_reg, pub_seen_reg, idle_reg, was_stale_reg;
    logic [15:0] tsp_reg, stale_cnt_reg, rej_cnt_reg;
    logic        stale_reg, onset_reg, take_reg;
    logic [JW-1:0] jcnt_reg;
    logic signed [31:0] cmd_cur_reg, vel_reg, tgt_cur_reg, dec_cur_reg;
    logic        m_valid_reg;
    logic [slsb_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic        m_last_reg;

    logic [6:0]  item_j_ext;
    logic [JW-1:0] item_j;
    logic        pop;
    logic        idle_n, stale_n, onset_n, bad_any;
    logic [15:0] tsp_n;

    logic signed [32:0] vel_diff;
    logic signed [31:0] vel_sat, tgt_new;
    logic signed [33:0] stg_clamp;

    logic signed [32:0] vel_ext, dec_ext, vel_mag, dec_mag, v_eff, live_d, step_ext;
    logic signed [33:0] stale_sum, stale_clamp;
    logic signed [31:0] cmd_new;
    logic        out_free, last_j;
    logic [6:0]  jcnt_ext;

    slsb_pkg::div_req_t       div_req;
    logic                     div_done;
    logic [31:0]              div_q;

    function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
        logic signed [33:0] r;
        r = v;
        if (r < 34'(lo)) begin
            r = 34'(lo);
        end
        if (r > 34'(hi)) begin
            r = 34'(hi);
        end
        return r;
    endfunction

    slsb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign item_j_ext = {3'b000, q_item.joint};
    assign item_j     = item_j_ext[JW-1:0];
    assign q_ready    = (state_reg == ST_IDLE);
    assign pop        = q_valid && q_ready;
    assign bad_any    = |stg_bad_reg;

    // watchdog for the tick about to start
    always_comb begin
        idle_n = idle_reg;
        tsp_n  = tsp_reg;
        if (pub_seen_reg) begin
            idle_n = 1'b0;
            tsp_n  = '0;
        end else if (!idle_reg && tsp_reg != 16'hFFFF) begin
            tsp_n = tsp_reg + 1'b1;
        end
        stale_n = (stale_limit != '0) && !idle_n && (tsp_n >= stale_limit);
        onset_n = stale_n && !was_stale_reg;
    end

    // velocity and new target for the current joint
    always_comb begin
        vel_diff = 33'(cmd_mem[jcnt_reg]) - 33'(prev_mem[jcnt_reg]);
        if (vel_diff > 33'sd2147483647) begin
            vel_sat = 32'sh7FFFFFFF;
        end else if (vel_diff < -33'sd2147483648) begin
            vel_sat = 32'sh80000000;
        end else begin
            vel_sat = vel_diff[31:0];
        end
        stg_clamp = clamp34(34'(stg_mem[jcnt_reg]), lo_mem[jcnt_reg], hi_mem[jcnt_reg]);
        tgt_new   = take_reg ? stg_clamp[31:0] : tgt_mem[jcnt_reg];
    end

    always_comb begin
        div_req.start    = (state_reg == ST_VEL) && onset_reg;
        div_req.neg      = vel_sat[31];
        div_req.dividend = vel_sat[31] ? (~vel_sat + 1'b1) : vel_sat;
        div_req.divisor  = decel_ticks;
    end

    // command update
    always_comb begin
        vel_ext   = 33'(vel_reg);
        dec_ext   = 33'(dec_cur_reg);
        vel_mag   = vel_ext[32] ? -vel_ext : vel_ext;
        dec_mag   = dec_ext[32] ? -dec_ext : dec_ext;
        v_eff     = (vel_mag <= dec_mag) ? '0 : (vel_ext - dec_ext);
        stale_sum = 34'(cmd_cur_reg) + 34'(v_eff);
        stale_clamp = clamp34(stale_sum, lo_mem[jcnt_reg], hi_mem[jcnt_reg]);
        live_d    = 33'(tgt_cur_reg) - 33'(cmd_cur_reg);
        step_ext  = {2'b00, step_mem[jcnt_reg]};
        if (stale_reg) begin
            cmd_new = stale_clamp[31:0];
        end else if (live_d > step_ext) begin
            cmd_new = cmd_cur_reg + 32'(step_mem[jcnt_reg]);
        end else if (live_d < -step_ext) begin
            cmd_new = cmd_cur_reg - 32'(step_mem[jcnt_reg]);
        end else begin
            cmd_new = tgt_cur_reg;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign last_j   = (jcnt_reg == JW'(NUM_JOINTS - 1));
    assign jcnt_ext = 7'(jcnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stg_bad_reg   <= '0;
            dec_vld_reg   <= '0;
            snap_pend_reg <= 1'b0;
            pub_seen_reg  <= 1'b0;
            idle_reg      <= 1'b1;
            tsp_reg       <= '0;
            was_stale_reg <= 1'b0;
            stale_cnt_reg <= '0;
            rej_cnt_reg   <= '0;
            stale_reg     <= 1'b0;
            onset_reg     <= 1'b0;
            take_reg      <= 1'b0;
            jcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (state_reg == ST_CMD && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        case (q_item.kind)
                            slsb_pkg::ACT_STAGE: begin
                                stg_bad_reg[item_j] <= q_item.not_finite;
                            end
                            slsb_pkg::ACT_PUBLISH: begin
                                snap_pend_reg <= 1'b1;
                                pub_seen_reg  <= 1'b1;
                            end
                            slsb_pkg::ACT_TICK: begin
                                pub_seen_reg  <= 1'b0;
                                idle_reg      <= idle_n;
                                tsp_reg       <= tsp_n;
                                stale_reg     <= stale_n;
                                onset_reg     <= onset_n;
                                was_stale_reg <= stale_n;
                                take_reg      <= !stale_n && snap_pend_reg && !bad_any;
                                jcnt_reg      <= '0;
                                if (onset_n && stale_cnt_reg != 16'hFFFF) begin
                                    stale_cnt_reg <= stale_cnt_reg + 1'b1;
                                end
                                if (!stale_n && snap_pend_reg) begin
                                    snap_pend_reg <= 1'b0;
                                    if (bad_any && rej_cnt_reg != 16'hFFFF) begin
                                        rej_cnt_reg <= rej_cnt_reg + 1'b1;
                                    end
                                end
                                state_reg <= ST_VEL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_VEL: begin
                    state_reg <= onset_reg ? ST_DIV : ST_CMD;
                end
                ST_DIV: begin
                    if (div_done) begin
                        dec_vld_reg[jcnt_reg] <= 1'b1;
                        state_reg <= ST_CMD;
                    end
                end
                ST_CMD: begin
                    if (out_free) begin
                        if (last_j) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            jcnt_reg  <= jcnt_reg + 1'b1;
                            state_reg <= ST_VEL;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_item.kind == slsb_pkg::ACT_STAGE) begin
            stg_mem[item_j] <= q_item.position;
        end
        if (pop && q_item.kind == slsb_pkg::ACT_LOAD) begin
            lo_mem[item_j]   <= q_item.low_limit;
            hi_mem[item_j]   <= q_item.high_limit;
            step_mem[item_j] <= q_item.step_limit;
            cmd_mem[item_j]  <= q_item.position;
            tgt_mem[item_j]  <= q_item.position;
            prev_mem[item_j] <= q_item.position;
        end
        if (state_reg == ST_VEL) begin
            cmd_cur_reg        <= cmd_mem[jcnt_reg];
            prev_mem[jcnt_reg] <= cmd_mem[jcnt_reg];
            vel_reg            <= vel_sat;
            tgt_cur_reg        <= tgt_new;
            tgt_mem[jcnt_reg]  <= tgt_new;
            dec_cur_reg        <= dec_vld_reg[jcnt_reg] ? dec_mem[jcnt_reg] : '0;
        end
        if (state_reg == ST_DIV && div_done) begin
            dec_mem[jcnt_reg] <= div_q;
            dec_cur_reg       <= div_q;
        end
        if (state_reg == ST_CMD && out_free) begin
            cmd_mem[jcnt_reg] <= cmd_new;
            m_data_reg <= {3'b000, rej_cnt_reg, stale_cnt_reg, stale_reg, cmd_new,
                           jcnt_ext[3:0]};
            m_last_reg <= last_j;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- src/joint_slew_limiter_with_stale_brake_core.sv -----
// top level of the joint slew limiter with stale brake
// Per-joint position command shaper. Stage, publish and load words enter the
// input queue and are carried out by the execution stage when it next pops
// the queue in its idle state. A tick produces one result word per joint; each
// joint is read in ST_VEL, then updated into the result register in ST_CMD.
// On the tick where the stream turns stale each joint also runs the shared
// bit-serial divider in ST_DIV, on that tick only. Output stalls hold the walk.
// The input queue holds four words, so the input side keeps accepting while a
// tick is being walked, until the queue is full.
// Configuration writes must be made while the block is idle.
module joint_slew_limiter_with_stale_brake_core #(
    parameter int NUM_JOINTS = slsb_pkg::NUM_JOINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // joint, position, not_finite, low_limit, high_limit, step_limit, zero pad
    input  logic [slsb_pkg::IN_DATA_W-1:0]   s_tdata,
    // action
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // joint_index, command, stale, stale_events, rejected, zero pad
    output logic [slsb_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [slsb_pkg::CNT_W-1:0]       cfg_wdata
);

    logic [slsb_pkg::CNT_W-1:0] stale_limit_reg;
    logic [slsb_pkg::CNT_W-1:0] decel_ticks_reg;
    logic                       q_valid, q_ready;
    slsb_pkg::item_t            q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_limit_reg <= '0;
            decel_ticks_reg <= slsb_pkg::CNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                slsb_pkg::CFG_STALE_LIMIT: stale_limit_reg <= cfg_wdata;
                slsb_pkg::CFG_DECEL_TICKS: decel_ticks_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    slsb_front #(.NUM_JOINTS(NUM_JOINTS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    slsb_back #(.NUM_JOINTS(NUM_JOINTS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .stale_limit (stale_limit_reg),
        .decel_ticks (decel_ticks_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- src/slsb_checker.sv -----
// port-level checks for the joint slew limiter, bound to the top level
module slsb_checker #(
    parameter int NUM_JOINTS = slsb_pkg::NUM_JOINTS_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [slsb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);

    localparam logic [6:0] LAST_J = 7'(NUM_JOINTS - 1);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_last_joint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3:0] == LAST_J[3:0])
        else $error("last word not on final joint");

    a_stale_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid || m_tdata[52:37] >= $past(m_tdata[52:37]))
        else $error("stale event count went down");

    a_rej_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid || m_tdata[68:53] >= $past(m_tdata[68:53]))
        else $error("reject count went down");

endmodule

bind joint_slew_limiter_with_stale_brake_core slsb_checker #(.NUM_JOINTS(NUM_JOINTS)) u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/joint_slew_limiter_with_stale_brake_core_test.sv -----
// testbench for the joint slew limiter with stale brake: directed table, random words, predictor
`timescale 1ns / 100ps

module joint_slew_limiter_with_stale_brake_core_test;

    localparam int JOINTS = 16;

    typedef struct {
        slsb_pkg::action_t act;
        logic [3:0]        joint;
        logic [31:0]       position;
        logic              not_finite;
        logic [31:0]       low_limit;
        logic [31:0]       high_limit;
        logic [30:0]       step_limit;
        bit                has_cmd0;
        logic [31:0]       cmd0;
    } cmd_word_t;

    typedef struct {
        logic [3:0]  joint_index;
        logic [31:0] command;
        logic        stale;
        logic        last;
        logic [15:0] stale_events;
        logic [15:0] rejected;
    } joint_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [slsb_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [slsb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            cfg_wr_en;
    logic                            cfg_index;
    logic [slsb_pkg::CNT_W-1:0]      cfg_wdata;

    joint_slew_limiter_with_stale_brake_core uut (.*);

    // shaper state mirror
    logic [15:0]        stale_limit_q;
    logic [15:0]        decel_ticks_q;
    logic signed [31:0] cmd_pos [JOINTS];
    logic signed [31:0] tgt_pos [JOINTS];
    logic signed [31:0] prev_pos [JOINTS];
    logic signed [31:0] brake_step [JOINTS];
    logic signed [31:0] lo_bound [JOINTS];
    logic signed [31:0] hi_bound [JOINTS];
    logic signed [31:0] slew [JOINTS];
    logic signed [31:0] staged [JOINTS];
    logic               staged_bad [JOINTS];
    bit                 snap_pending;
    bit                 publish_flag;
    bit                 never_published;
    logic [15:0]        ticks_idle;
    bit                 stale_q;
    logic [15:0]        stale_events_q;
    logic [15:0]        reject_q;

    joint_result_t pending_results[$];
    int  errors;
    int  tx_idle_pct;
    int  rx_idle_pct;
    cmd_word_t directed_rows[$];

    initial begin
        aclk = 1'b0;
    end
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint clamp_joint(longint v, int j);
        if (v < lo_bound[j]) v = lo_bound[j];
        if (v > hi_bound[j]) v = hi_bound[j];
        return v;
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic shape_word(input cmd_word_t w);
        longint vel [JOINTS];
        longint d;
        longint s;
        longint dt;
        bit     stale;
        bit     bad;
        joint_result_t r;
        case (w.act)
            slsb_pkg::ACT_STAGE: begin
                staged[w.joint] = w.position;
                staged_bad[w.joint] = w.not_finite;
            end
            slsb_pkg::ACT_PUBLISH: begin
                snap_pending = 1;
                publish_flag = 1;
            end
            slsb_pkg::ACT_LOAD: begin
                lo_bound[w.joint] = w.low_limit;
                hi_bound[w.joint] = w.high_limit;
                slew[w.joint] = {1'b0, w.step_limit};
                cmd_pos[w.joint] = w.position;
                tgt_pos[w.joint] = w.position;
                prev_pos[w.joint] = w.position;
            end
            default: begin
                for (int i = 0; i < JOINTS; i++) begin
                    d = longint'(cmd_pos[i]) - longint'(prev_pos[i]);
                    if (d > 64'sd2147483647) d = 64'sd2147483647;
                    if (d < -64'sd2147483648) d = -64'sd2147483648;
                    vel[i] = d;
                    prev_pos[i] = cmd_pos[i];
                end
                if (publish_flag) begin
                    publish_flag = 0;
                    never_published = 0;
                    ticks_idle = 0;
                end else if (!never_published && ticks_idle != 16'hFFFF) begin
                    ticks_idle++;
                end
                stale = stale_limit_q != 0 && !never_published && ticks_idle >= stale_limit_q;
                if (stale && !stale_q) begin
                    if (stale_events_q != 16'hFFFF) stale_events_q++;
                    dt = decel_ticks_q == 0 ? 1 : longint'(decel_ticks_q);
                    for (int i = 0; i < JOINTS; i++) brake_step[i] = vel[i] / dt;
                end
                stale_q = stale;
                if (stale) begin
                    for (int i = 0; i < JOINTS; i++) begin
                        d = vel[i];
                        if (magnitude(d) <= magnitude(longint'(brake_step[i]))) d = 0;
                        else d -= longint'(brake_step[i]);
                        cmd_pos[i] = clamp_joint(longint'(cmd_pos[i]) + d, i);
                    end
                end else begin
                    if (snap_pending) begin
                        snap_pending = 0;
                        bad = 0;
                        for (int i = 0; i < JOINTS; i++) if (staged_bad[i]) bad = 1;
                        if (bad) begin
                            if (reject_q != 16'hFFFF) reject_q++;
                        end else begin
                            for (int i = 0; i < JOINTS; i++)
                                tgt_pos[i] = clamp_joint(longint'(staged[i]), i);
                        end
                    end
                    for (int i = 0; i < JOINTS; i++) begin
                        d = longint'(tgt_pos[i]) - longint'(cmd_pos[i]);
                        s = longint'(slew[i]);
                        if (d > s) cmd_pos[i] = longint'(cmd_pos[i]) + s;
                        else if (d < -s) cmd_pos[i] = longint'(cmd_pos[i]) - s;
                        else cmd_pos[i] = tgt_pos[i];
                    end
                end
                for (int i = 0; i < JOINTS; i++) begin
                    r.joint_index = i[3:0];
                    r.command = cmd_pos[i];
                    r.stale = stale;
                    r.last = (i == JOINTS - 1);
                    r.stale_events = stale_events_q;
                    r.rejected = reject_q;
                    pending_results.insert(pending_results.size(), r);
                end
            end
        endcase
    endtask

    task automatic send_word(input cmd_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.act;
        s_tdata <= {4'd0, w.step_limit, w.high_limit, w.low_limit, w.not_finite,
                    w.position, w.joint};
        do @(posedge aclk); while (!s_tready);
        shape_word(w);
        if (w.has_cmd0 && cmd_pos[0] !== w.cmd0) begin
            $display("%0t directed joint 0 command: expected %h, actual %h",
                     $time, w.cmd0, cmd_pos[0]);
            errors++;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == slsb_pkg::CFG_STALE_LIMIT) stale_limit_q = val;
        else decel_ticks_q = val;
    endtask

    function automatic logic [31:0] rand_pos();
        int k;
        k = $urandom_range(99);
        if (k < 70) return $urandom_range(2097152) - 1048576;
        if (k < 80) return k[0] ? 32'h7FFFFFFF : 32'h80000000;
        return $urandom;
    endfunction

    function automatic cmd_word_t mk_word(slsb_pkg::action_t a, int j, logic [31:0] p,
                                          logic nf, logic [31:0] lo, logic [31:0] hi,
                                          logic [30:0] st, bit chk, logic [31:0] c0);
        cmd_word_t w;
        w.act = a; w.joint = j[3:0]; w.position = p; w.not_finite = nf;
        w.low_limit = lo; w.high_limit = hi; w.step_limit = st;
        w.has_cmd0 = chk; w.cmd0 = c0;
        return w;
    endfunction

    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        int k;
        logic [31:0] a;
        logic [31:0] b;
        w = mk_word(slsb_pkg::ACT_TICK, $urandom_range(15), $urandom,
                    1'($urandom_range(1)), $urandom, $urandom, 31'($urandom), 0, 0);
        k = $urandom_range(99);
        if (k < 40) begin
            w.act = slsb_pkg::ACT_TICK;
        end else if (k < 68) begin
            w.act = slsb_pkg::ACT_STAGE;
            w.position = rand_pos();
            w.not_finite = $urandom_range(99) < 8;
        end else if (k < 82) begin
            w.act = slsb_pkg::ACT_PUBLISH;
        end else begin
            w.act = slsb_pkg::ACT_LOAD;
            a = rand_pos();
            b = rand_pos();
            if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
                w.low_limit = b; w.high_limit = a;
            end else begin
                w.low_limit = a; w.high_limit = b;
            end
            w.position = $urandom_range(3) == 0 ? rand_pos() : w.low_limit;
            k = $urandom_range(9);
            w.step_limit = k < 6 ? 31'($urandom_range(200000))
                                 : (k < 8 ? 31'h7FFFFFFF : 31'($urandom));
        end
        return w;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        joint_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: actual %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[3:0] !== e.joint_index) begin
                    $display("%0t joint_index: expected %h, actual %h",
                             $time, e.joint_index, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== e.command) begin
                    $display("%0t command j%0d: expected %h, actual %h",
                             $time, e.joint_index, e.command, m_tdata[35:4]);
                    errors++;
                end
                if (m_tdata[36] !== e.stale) begin
                    $display("%0t stale: expected %b, actual %b", $time, e.stale, m_tdata[36]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t last: expected %b, actual %b", $time, e.last, m_tlast);
                    errors++;
                end
                if (m_tdata[52:37] !== e.stale_events) begin
                    $display("%0t stale_events: expected %h, actual %h",
                             $time, e.stale_events, m_tdata[52:37]);
                    errors++;
                end
                if (m_tdata[68:53] !== e.rejected) begin
                    $display("%0t rejected: expected %h, actual %h",
                             $time, e.rejected, m_tdata[68:53]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int count;
        logic [15:0] limits [5];
        logic [15:0] decels [5];
        errors = 0;
        tx_idle_pct = 30;
        rx_idle_pct = 54;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = slsb_pkg::ACT_TICK;
        cfg_wr_en = 1'b0;
        cfg_index = slsb_pkg::CFG_STALE_LIMIT;
        cfg_wdata = '0;
        stale_limit_q = 0;
        decel_ticks_q = 1;
        for (int i = 0; i < JOINTS; i++) begin
            brake_step[i] = 0;
            staged_bad[i] = 0;
        end
        snap_pending = 0;
        publish_flag = 0;
        never_published = 1;
        ticks_idle = 0;
        stale_q = 0;
        stale_events_q = 0;
        reject_q = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every joint row and staged entry written before any tick or publish
        send_word(mk_word(slsb_pkg::ACT_LOAD, 0, 0, 0, -1000, 1000, 100, 0, 0));
        for (int j = 1; j < JOINTS; j++)
            send_word(mk_word(slsb_pkg::ACT_LOAD, j, j * 65536, 0, -1048576, 1048576,
                              4096, 0, 0));
        for (int j = 0; j < JOINTS; j++)
            send_word(mk_word(slsb_pkg::ACT_STAGE, j, j * 65536, 0, 0, 0, 0, 0, 0));

        directed_rows = {
            mk_word(slsb_pkg::ACT_TICK, 15, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    31'h7FFFFFFF, 1, 0),
            mk_word(slsb_pkg::ACT_STAGE, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_PUBLISH, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1, 100),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1, 200),
            mk_word(slsb_pkg::ACT_STAGE, 0, 32'h80000000, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_PUBLISH, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1, 100),
            mk_word(slsb_pkg::ACT_LOAD, 0, 0, 0, -8, 8, 31'h7FFFFFFF, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1, 0),
            mk_word(slsb_pkg::ACT_STAGE, 0, 5, 1, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_PUBLISH, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1, 0),
            mk_word(slsb_pkg::ACT_STAGE, 0, 7, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_PUBLISH, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1, 7),
            mk_word(slsb_pkg::ACT_LOAD, 1, 0, 0, 100, -100, 0, 0, 0),
            mk_word(slsb_pkg::ACT_LOAD, 15, 32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF,
                    31'h7FFFFFFF, 0, 0),
            mk_word(slsb_pkg::ACT_LOAD, 14, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF,
                    0, 0, 0),
            mk_word(slsb_pkg::ACT_STAGE, 1, 50, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_STAGE, 15, 32'h80000000, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_PUBLISH, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_word(slsb_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0)
        };
        foreach (directed_rows[i]) send_word(directed_rows[i]);
        settle();

        limits = '{16'd3, 16'd2, 16'd1, 16'd65535, 16'd0};
        decels = '{16'd1, 16'd65535, 16'd3, 16'd1, 16'd2};
        count = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(slsb_pkg::CFG_STALE_LIMIT, limits[ph]);
            write_reg(slsb_pkg::CFG_DECEL_TICKS, decels[ph]);
            for (int n = 0; n < 41; n++) begin
                if (count < 68) begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 54;
                end else if (count < 137) begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 30;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                send_word(rand_word());
                count++;
            end
            settle();
        end

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
